### hw/rtl/mmts_pkg.sv
// Package for the multi-mode task scheduler.
// Holds field widths, mode and register codes, and the controller/datapath structs.
// No dependencies.
`default_nettype none

package mmts_pkg;

  localparam int unsigned TIME_W        = 16;
  localparam int unsigned ID_W          = 8;
  localparam int unsigned SLICE_W       = 8;
  localparam int unsigned MODE_W        = 2;
  localparam int unsigned QUANT_W       = 8;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = 8;
  localparam int unsigned DEF_MAX_TASKS = 16;

  localparam logic [MODE_W-1:0] MODE_FCFS = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SRTF = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RR   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 1'b1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [TIME_W-1:0]  TIME_MAX  = '1;
  localparam logic [SLICE_W-1:0] SLICE_MAX = '1;

  typedef struct packed {
    logic capture;
    logic adm_step;
    logic adm_fin;
    logic sel_prep;
    logic sel_step;
    logic sel_fin;
    logic run;
    logic load;
  } mmts_cmd_t;

  typedef struct packed {
    logic in_tick;
    logic out_free;
  } mmts_stat_t;

endpackage

`default_nettype wire

### hw/rtl/mmts_ctrl.sv
// Controller state machine of the multi-mode task scheduler.
// Sequences the admission scan, the selection scan and the commit of each word.
// Depends on mmts_pkg.
`default_nettype none

module mmts_ctrl #(
  parameter int unsigned MAX_TASKS = mmts_pkg::DEF_MAX_TASKS
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  mmts_pkg::mmts_stat_t         stat_i,
  output mmts_pkg::mmts_cmd_t          cmd_o,
  output logic [$clog2(MAX_TASKS)-1:0] scan_idx_o
);
  import mmts_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_TASKS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TASKS - 1);

  typedef enum logic [7:0] {
    ST_IDLE      = 8'b0000_0001,
    ST_ADMIT     = 8'b0000_0010,
    ST_ADMIT_FIN = 8'b0000_0100,
    ST_SEL_PREP  = 8'b0000_1000,
    ST_SEL_SCAN  = 8'b0001_0000,
    ST_SEL_FIN   = 8'b0010_0000,
    ST_RUN       = 8'b0100_0000,
    ST_LOAD      = 8'b1000_0000
  } state_e;

  state_e          state_q, state_d;
  logic [IDX_W-1:0] scan_q, scan_d;
  logic             last;

  assign last       = (scan_q == LAST_IDX);
  assign scan_idx_o = scan_q;

  always_comb begin
    state_d    = state_q;
    scan_d     = scan_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        scan_d     = '0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = (stat_i.in_tick == OP_TICK) ? ST_ADMIT : ST_LOAD;
        end
      end
      ST_ADMIT: begin
        cmd_o.adm_step = 1'b1;
        scan_d = scan_q + 1'b1;
        if (last) begin
          state_d = ST_ADMIT_FIN;
        end
      end
      ST_ADMIT_FIN: begin
        cmd_o.adm_fin = 1'b1;
        state_d = ST_SEL_PREP;
      end
      ST_SEL_PREP: begin
        cmd_o.sel_prep = 1'b1;
        scan_d  = '0;
        state_d = ST_SEL_SCAN;
      end
      ST_SEL_SCAN: begin
        cmd_o.sel_step = 1'b1;
        scan_d = scan_q + 1'b1;
        if (last) begin
          state_d = ST_SEL_FIN;
        end
      end
      ST_SEL_FIN: begin
        cmd_o.sel_fin = 1'b1;
        state_d = ST_RUN;
      end
      ST_RUN: begin
        if (stat_i.out_free) begin
          cmd_o.run = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_LOAD: begin
        if (stat_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      scan_q  <= '0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
    end
  end

  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("more than one datapath command issued");

  a_admit_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADMIT && last) |=> (state_q == ST_ADMIT_FIN))
    else $error("admission scan did not end after the last slot");

  a_sel_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEL_PREP) |=> (state_q == ST_SEL_SCAN && scan_q == '0))
    else $error("selection scan did not start at slot zero");

endmodule

`default_nettype wire

### hw/rtl/mmts_dp.sv
// Datapath of the multi-mode task scheduler: task table, ready queue ranks,
// scan comparators, timing arithmetic, configuration and the result register.
// Depends on mmts_pkg.
`default_nettype none

module mmts_dp #(
  parameter int unsigned MAX_TASKS = mmts_pkg::DEF_MAX_TASKS
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  mmts_pkg::mmts_cmd_t                    cmd_i,
  input  wire [$clog2(MAX_TASKS)-1:0]            scan_idx_i,
  output mmts_pkg::mmts_stat_t                   stat_o,
  input  wire                                    cfg_we_i,
  input  wire [mmts_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  wire [mmts_pkg::CFG_DATA_W-1:0]         cfg_wdata_i,
  input  wire                                    operation_i,
  input  wire [mmts_pkg::ID_W-1:0]               task_id_i,
  input  wire [mmts_pkg::TIME_W-1:0]             arrival_time_i,
  input  wire [mmts_pkg::TIME_W-1:0]             burst_length_i,
  output logic                                   out_valid_o,
  input  wire                                    out_ready_i,
  output logic [mmts_pkg::TIME_W-1:0]            current_time_o,
  output logic                                   load_rejected_o,
  output logic                                   running_valid_o,
  output logic [mmts_pkg::ID_W-1:0]              running_id_o,
  output logic                                   finished_o,
  output logic [mmts_pkg::TIME_W-1:0]            turnaround_time_o,
  output logic [mmts_pkg::TIME_W-1:0]            waiting_time_o,
  output logic [mmts_pkg::TIME_W-1:0]            response_time_o,
  output logic                                   all_done_o
);
  import mmts_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_TASKS);
  localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_TASKS);

  logic [MODE_W-1:0]  mode_q;
  logic [QUANT_W-1:0] quantum_q;

  logic [ID_W-1:0]   in_id_q;
  logic [TIME_W-1:0] in_arr_q, in_burst_q;

  logic [ID_W-1:0]   slot_id_q    [MAX_TASKS];
  logic [TIME_W-1:0] slot_arr_q   [MAX_TASKS];
  logic [TIME_W-1:0] slot_burst_q [MAX_TASKS];
  logic [TIME_W-1:0] slot_rem_q   [MAX_TASKS];
  logic [TIME_W-1:0] slot_first_q [MAX_TASKS];
  logic [IDX_W-1:0]  rank_q       [MAX_TASKS];
  logic [IDX_W-1:0]  cnt_q        [MAX_TASKS];
  logic [MAX_TASKS-1:0] joined_q, started_q, inq_q;

  logic [CNT_W-1:0]   ready_cnt_q, loaded_q, done_q, ncand_q;
  logic [TIME_W-1:0]  time_q;
  logic [SLICE_W-1:0] slice_q;
  logic               act_v_q;
  logic [IDX_W-1:0]   act_q;

  logic               have_q, from_q;
  logic [IDX_W-1:0]   best_idx_q, best_rank_q;
  logic [TIME_W-1:0]  best_rem_q, best_arr_q;

  logic out_valid_q;

  logic              is_srtf, is_rr, out_free, scan_en;
  logic [IDX_W-1:0]  rd_idx, rd_rank;
  logic [TIME_W-1:0] rd_arr, rd_rem, rd_burst, rd_first;
  logic [ID_W-1:0]   rd_id;
  logic              cand_k, better, take, expire, reject;
  logic [QUANT_W-1:0] q_eff;
  logic [CNT_W-1:0]  rc_mid;
  logic [TIME_W-1:0] first_eff, rem_new, ft, ta, wt, rt;

  assign is_srtf  = (mode_q == MODE_SRTF);
  assign is_rr    = (mode_q == MODE_RR);
  assign out_free = !out_valid_q || out_ready_i;
  assign stat_o   = '{in_tick: operation_i, out_free: out_free};
  assign out_valid_o = out_valid_q;

  assign scan_en  = cmd_i.adm_step || cmd_i.sel_step;
  assign rd_idx   = scan_en ? scan_idx_i : act_q;
  assign rd_arr   = slot_arr_q[rd_idx];
  assign rd_rem   = slot_rem_q[rd_idx];
  assign rd_burst = slot_burst_q[rd_idx];
  assign rd_first = slot_first_q[rd_idx];
  assign rd_id    = slot_id_q[rd_idx];
  assign rd_rank  = rank_q[rd_idx];

  assign cand_k = ({1'b0, scan_idx_i} < loaded_q) && !joined_q[scan_idx_i]
                  && (rd_arr <= time_q);

  always_comb begin
    case (mode_q)
      MODE_RR:   better = rd_rank < best_rank_q;
      MODE_SRTF: better = (rd_rem < best_rem_q) ||
                          ((rd_rem == best_rem_q) && ((rd_arr < best_arr_q) ||
                          ((rd_arr == best_arr_q) && (scan_idx_i < best_idx_q))));
      default:   better = (rd_arr < best_arr_q) ||
                          ((rd_arr == best_arr_q) && (scan_idx_i < best_idx_q));
    endcase
  end

  assign q_eff  = (quantum_q == '0) ? QUANT_W'(1) : quantum_q;
  assign expire = is_rr && act_v_q && (slice_q >= q_eff);
  assign rc_mid = ready_cnt_q + ncand_q;
  assign take   = from_q && (is_srtf || !act_v_q);
  assign reject = (loaded_q >= CNT_FULL) || (in_burst_q == '0);

  assign first_eff = started_q[act_q] ? rd_first : time_q;
  assign rem_new   = (rd_rem != '0) ? rd_rem - 1'b1 : rd_rem;
  assign ft        = (time_q != TIME_MAX) ? time_q + 1'b1 : TIME_MAX;
  assign ta        = (ft >= rd_arr) ? ft - rd_arr : '0;
  assign wt        = (ta >= rd_burst) ? ta - rd_burst : '0;
  assign rt        = (first_eff >= rd_arr) ? first_eff - rd_arr : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_id_q    <= task_id_i;
      in_arr_q   <= arrival_time_i;
      in_burst_q <= burst_length_i;
    end
    for (int i = 0; i < MAX_TASKS; i++) begin
      if (cmd_i.capture) begin
        cnt_q[i] <= '0;
      end else if (cmd_i.adm_step && cand_k && ((rd_arr < slot_arr_q[i]) ||
                   ((rd_arr == slot_arr_q[i]) && (scan_idx_i < IDX_W'(i))))) begin
        cnt_q[i] <= cnt_q[i] + 1'b1;
      end
      if (cmd_i.adm_fin && (CNT_W'(i) < loaded_q) && !joined_q[i] &&
          (slot_arr_q[i] <= time_q)) begin
        rank_q[i] <= IDX_W'(ready_cnt_q + CNT_W'(cnt_q[i]));
      end
      if (cmd_i.sel_fin && take && inq_q[i] && (rank_q[i] > best_rank_q)) begin
        rank_q[i] <= rank_q[i] - 1'b1;
      end
    end
    if (cmd_i.adm_fin && expire) begin
      rank_q[act_q] <= IDX_W'(rc_mid);
    end
    if (cmd_i.sel_fin && take && is_srtf && act_v_q) begin
      rank_q[act_q] <= IDX_W'(ready_cnt_q - 1'b1);
    end
    if (cmd_i.load && !reject) begin
      slot_id_q[loaded_q[IDX_W-1:0]]    <= in_id_q;
      slot_arr_q[loaded_q[IDX_W-1:0]]   <= in_arr_q;
      slot_burst_q[loaded_q[IDX_W-1:0]] <= in_burst_q;
      slot_rem_q[loaded_q[IDX_W-1:0]]   <= in_burst_q;
    end
    if (cmd_i.run && act_v_q) begin
      slot_rem_q[act_q] <= rem_new;
      if (!started_q[act_q]) begin
        slot_first_q[act_q] <= time_q;
      end
    end
    if (cmd_i.sel_prep) begin
      best_idx_q <= act_q;
      best_rem_q <= rd_rem;
      best_arr_q <= rd_arr;
    end else if (cmd_i.sel_step && inq_q[scan_idx_i] && (!have_q || better)) begin
      best_idx_q  <= scan_idx_i;
      best_rank_q <= rd_rank;
      best_rem_q  <= rd_rem;
      best_arr_q  <= rd_arr;
    end
    if (cmd_i.run || cmd_i.load) begin
      current_time_o    <= time_q;
      load_rejected_o   <= cmd_i.load && reject;
      running_valid_o   <= cmd_i.run && act_v_q;
      running_id_o      <= (cmd_i.run && act_v_q) ? rd_id : '0;
      finished_o        <= cmd_i.run && act_v_q && (rem_new == '0);
      turnaround_time_o <= (cmd_i.run && act_v_q && (rem_new == '0)) ? ta : '0;
      waiting_time_o    <= (cmd_i.run && act_v_q && (rem_new == '0)) ? wt : '0;
      response_time_o   <= (cmd_i.run && act_v_q && (rem_new == '0)) ? rt : '0;
      if (cmd_i.run) begin
        all_done_o <= ((done_q + CNT_W'(act_v_q && (rem_new == '0))) == loaded_q);
      end else begin
        all_done_o <= (done_q == (loaded_q + CNT_W'(!reject)));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_FCFS;
      quantum_q   <= QUANT_W'(1);
      joined_q    <= '0;
      started_q   <= '0;
      inq_q       <= '0;
      ready_cnt_q <= '0;
      loaded_q    <= '0;
      done_q      <= '0;
      ncand_q     <= '0;
      time_q      <= '0;
      slice_q     <= '0;
      act_v_q     <= 1'b0;
      act_q       <= '1;
      have_q      <= 1'b0;
      from_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_MODE:    mode_q    <= cfg_wdata_i[MODE_W-1:0];
          CFG_QUANTUM: quantum_q <= cfg_wdata_i[QUANT_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd_i.capture) begin
        ncand_q <= '0;
      end else if (cmd_i.adm_step && cand_k) begin
        ncand_q <= ncand_q + 1'b1;
      end
      if (cmd_i.adm_fin) begin
        for (int i = 0; i < MAX_TASKS; i++) begin
          if ((CNT_W'(i) < loaded_q) && !joined_q[i] && (slot_arr_q[i] <= time_q)) begin
            joined_q[i] <= 1'b1;
            inq_q[i]    <= 1'b1;
          end
        end
        if (expire) begin
          inq_q[act_q] <= 1'b1;
          ready_cnt_q  <= rc_mid + 1'b1;
          act_v_q      <= 1'b0;
        end else begin
          ready_cnt_q  <= rc_mid;
        end
      end
      if (cmd_i.sel_prep) begin
        have_q <= is_srtf && act_v_q;
        from_q <= 1'b0;
      end else if (cmd_i.sel_step && inq_q[scan_idx_i] && (!have_q || better)) begin
        have_q <= 1'b1;
        from_q <= 1'b1;
      end
      if (cmd_i.sel_fin && take) begin
        inq_q[best_idx_q] <= 1'b0;
        if (is_srtf && act_v_q) begin
          inq_q[act_q] <= 1'b1;
        end else begin
          ready_cnt_q  <= ready_cnt_q - 1'b1;
        end
        act_q   <= best_idx_q;
        act_v_q <= 1'b1;
        slice_q <= '0;
      end
      if (cmd_i.run) begin
        if (act_v_q) begin
          started_q[act_q] <= 1'b1;
          if (slice_q != SLICE_MAX) begin
            slice_q <= slice_q + 1'b1;
          end
          if (rem_new == '0) begin
            done_q  <= done_q + 1'b1;
            act_v_q <= 1'b0;
          end
        end
        if (time_q != TIME_MAX) begin
          time_q <= time_q + 1'b1;
        end
      end
      if (cmd_i.load && !reject) begin
        started_q[loaded_q[IDX_W-1:0]] <= 1'b0;
        joined_q[loaded_q[IDX_W-1:0]]  <= 1'b0;
        loaded_q <= loaded_q + 1'b1;
      end
      if (cmd_i.run || cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  a_rc_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_cnt_q == CNT_W'($countones(inq_q)))
    else $error("ready count disagrees with queued slots");

  a_act_not_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_v_q |-> !inq_q[act_q])
    else $error("running task is also in the ready queue");

  a_done_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q <= loaded_q)
    else $error("more tasks finished than loaded");

endmodule

`default_nettype wire

### hw/rtl/multi_mode_task_scheduler.sv
// Top level of the multi-mode task scheduler.
// Instantiates mmts_ctrl and mmts_dp; depends on mmts_pkg.
// A load word goes from idle straight to the load state. A tick word runs one
// admission scan and one selection scan over the task table at one slot per
// cycle, then the run state; load and run wait on a held result. A new word
// is taken while the previous result still waits on the output.
`default_nettype none

module multi_mode_task_scheduler #(
  parameter int unsigned MAX_TASKS = mmts_pkg::DEF_MAX_TASKS
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_we_i,
  input  wire [mmts_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire [mmts_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire                               operation_i,
  input  wire [mmts_pkg::ID_W-1:0]          task_id_i,
  input  wire [mmts_pkg::TIME_W-1:0]        arrival_time_i,
  input  wire [mmts_pkg::TIME_W-1:0]        burst_length_i,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output logic [mmts_pkg::TIME_W-1:0]       current_time_o,
  output logic                              load_rejected_o,
  output logic                              running_valid_o,
  output logic [mmts_pkg::ID_W-1:0]         running_id_o,
  output logic                              finished_o,
  output logic [mmts_pkg::TIME_W-1:0]       turnaround_time_o,
  output logic [mmts_pkg::TIME_W-1:0]       waiting_time_o,
  output logic [mmts_pkg::TIME_W-1:0]       response_time_o,
  output logic                              all_done_o
);
  import mmts_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_TASKS);

  mmts_cmd_t        cmd;
  mmts_stat_t       stat;
  logic [IDX_W-1:0] scan_idx;

  mmts_ctrl #(
    .MAX_TASKS (MAX_TASKS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .scan_idx_o (scan_idx)
  );

  mmts_dp #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .scan_idx_i        (scan_idx),
    .stat_o            (stat),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .operation_i       (operation_i),
    .task_id_i         (task_id_i),
    .arrival_time_i    (arrival_time_i),
    .burst_length_i    (burst_length_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .current_time_o    (current_time_o),
    .load_rejected_o   (load_rejected_o),
    .running_valid_o   (running_valid_o),
    .running_id_o      (running_id_o),
    .finished_o        (finished_o),
    .turnaround_time_o (turnaround_time_o),
    .waiting_time_o    (waiting_time_o),
    .response_time_o   (response_time_o),
    .all_done_o        (all_done_o)
  );

endmodule

`default_nettype wire

### tb/tb_multi_mode_task_scheduler.sv
// Testbench for multi_mode_task_scheduler: directed and random load and tick words,
// checked against a scheduler predictor kept in the bench. Depends on mmts_pkg and the RTL.
// The sender works in bursts with gaps, the receiver stalls on a pattern of its own.
`default_nettype none

module tb_multi_mode_task_scheduler;
  timeunit 1ns;
  timeprecision 1ps;
  import mmts_pkg::*;

  localparam int SLOTS = 16;
  localparam int LIMIT = 600000;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    logic [TIME_W-1:0] ctime;
    logic              rej;
    logic              runv;
    logic [ID_W-1:0]   rid;
    logic              fin;
    logic [TIME_W-1:0] tat;
    logic [TIME_W-1:0] wt;
    logic [TIME_W-1:0] rt;
    logic              alld;
  } sched_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic operation_i = 1'b0;
  logic [ID_W-1:0] task_id_i = '0;
  logic [TIME_W-1:0] arrival_time_i = '0;
  logic [TIME_W-1:0] burst_length_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [TIME_W-1:0] current_time_o;
  logic load_rejected_o, running_valid_o, finished_o, all_done_o;
  logic [ID_W-1:0] running_id_o;
  logic [TIME_W-1:0] turnaround_time_o, waiting_time_o, response_time_o;

  multi_mode_task_scheduler dut (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Scheduler state as the bench sees it.
  logic            tk_valid [SLOTS];
  logic            tk_started [SLOTS];
  logic            tk_joined [SLOTS];
  logic [ID_W-1:0] tk_id [SLOTS];
  int unsigned     tk_arr [SLOTS];
  int unsigned     tk_burst [SLOTS];
  int unsigned     tk_rem [SLOTS];
  int unsigned     tk_first [SLOTS];
  int unsigned     ready_q [SLOTS];
  int unsigned     ready_n, sys_time, slice_n, act_slot, n_loaded, n_done;
  bit              act_on;
  logic [MODE_W-1:0]  cur_mode;
  logic [QUANT_W-1:0] cur_quant;

  sched_res_t expected_q[$];
  int errors = 0;
  int cycles = 0;
  int burst_left = 0;

  function automatic void ready_push(int unsigned s);
    if (ready_n < SLOTS) begin
      ready_q[ready_n] = s;
      ready_n++;
    end
  endfunction

  function automatic void ready_drop(int unsigned pos);
    if (pos < ready_n) begin
      for (int unsigned i = pos; i + 1 < ready_n; i++) ready_q[i] = ready_q[i+1];
      ready_n--;
    end
  endfunction

  function automatic void admit_arrivals(int unsigned t);
    bit found;
    int unsigned best;
    for (int r = 0; r < SLOTS; r++) begin
      found = 0;
      best = 0;
      for (int unsigned s = 0; s < n_loaded; s++) begin
        if (tk_valid[s] && !tk_joined[s] && tk_arr[s] <= t)
          if (!found || tk_arr[s] < tk_arr[best]) begin
            best = s;
            found = 1;
          end
      end
      if (!found) return;
      tk_joined[best] = 1'b1;
      ready_push(best);
    end
  endfunction

  function automatic bit shorter_first(int unsigned a, int unsigned b);
    if (tk_rem[a] != tk_rem[b]) return tk_rem[a] < tk_rem[b];
    if (tk_arr[a] != tk_arr[b]) return tk_arr[a] < tk_arr[b];
    return a < b;
  endfunction

  function automatic void choose_task();
    int unsigned q, best, pos, s, b;
    bit have, from_q;
    q = (cur_quant == 0) ? 1 : cur_quant;
    if (cur_mode == MODE_RR) begin
      if (act_on && slice_n >= q) begin
        ready_push(act_slot);
        act_on = 0;
      end
      if (!act_on && ready_n > 0) begin
        act_slot = ready_q[0];
        ready_drop(0);
        act_on = 1;
        slice_n = 0;
      end
    end else if (cur_mode == MODE_SRTF) begin
      have = act_on;
      best = act_slot;
      pos = 0;
      from_q = 0;
      for (int unsigned i = 0; i < ready_n; i++) begin
        s = ready_q[i];
        if (!have || shorter_first(s, best)) begin
          best = s;
          pos = i;
          have = 1;
          from_q = 1;
        end
      end
      if (from_q) begin
        ready_drop(pos);
        if (act_on) ready_push(act_slot);
        act_slot = best;
        act_on = 1;
        slice_n = 0;
      end
    end else if (!act_on && ready_n > 0) begin
      pos = 0;
      for (int unsigned i = 1; i < ready_n; i++) begin
        s = ready_q[i];
        b = ready_q[pos];
        if (tk_arr[s] < tk_arr[b] || (tk_arr[s] == tk_arr[b] && s < b)) pos = i;
      end
      act_slot = ready_q[pos];
      ready_drop(pos);
      act_on = 1;
      slice_n = 0;
    end
  endfunction

  function automatic sched_res_t schedule_word(logic op, logic [ID_W-1:0] id,
                                               logic [TIME_W-1:0] arr,
                                               logic [TIME_W-1:0] bur);
    sched_res_t r;
    int unsigned s, ft, ta;
    r = '{default: '0};
    r.ctime = sys_time[TIME_W-1:0];
    if (op == OP_LOAD) begin
      if (n_loaded >= SLOTS || bur == 0) r.rej = 1'b1;
      else begin
        s = n_loaded;
        tk_valid[s] = 1'b1;
        tk_id[s] = id;
        tk_arr[s] = arr;
        tk_burst[s] = bur;
        tk_rem[s] = bur;
        tk_started[s] = 1'b0;
        tk_first[s] = 0;
        tk_joined[s] = 1'b0;
        n_loaded++;
      end
    end else begin
      admit_arrivals(sys_time);
      choose_task();
      if (act_on) begin
        s = act_slot;
        r.runv = 1'b1;
        r.rid = tk_id[s];
        if (!tk_started[s]) begin
          tk_started[s] = 1'b1;
          tk_first[s] = sys_time;
        end
        if (tk_rem[s] > 0) tk_rem[s]--;
        if (slice_n < SLICE_MAX) slice_n++;
        if (tk_rem[s] == 0) begin
          ft = (sys_time < TIME_MAX) ? sys_time + 1 : TIME_MAX;
          ta = (ft >= tk_arr[s]) ? ft - tk_arr[s] : 0;
          r.fin = 1'b1;
          r.tat = TIME_W'(ta);
          r.wt = TIME_W'((ta >= tk_burst[s]) ? ta - tk_burst[s] : 0);
          r.rt = TIME_W'((tk_first[s] >= tk_arr[s]) ? tk_first[s] - tk_arr[s] : 0);
          n_done++;
          act_on = 0;
        end
      end
      if (sys_time < TIME_MAX) sys_time++;
    end
    r.alld = (n_done == n_loaded);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch at time %0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    sched_res_t e;
    cycles <= cycles + 1;
    if (out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result words pending", 1, 0);
      end else begin
        e = expected_q.pop_front();
        if (current_time_o !== e.ctime) report_mismatch("current_time", current_time_o, e.ctime);
        if (load_rejected_o !== e.rej) report_mismatch("load_rejected", load_rejected_o, e.rej);
        if (running_valid_o !== e.runv) report_mismatch("running_valid", running_valid_o, e.runv);
        if (running_id_o !== e.rid) report_mismatch("running_id", running_id_o, e.rid);
        if (finished_o !== e.fin) report_mismatch("finished", finished_o, e.fin);
        if (turnaround_time_o !== e.tat) report_mismatch("turnaround", turnaround_time_o, e.tat);
        if (waiting_time_o !== e.wt) report_mismatch("waiting", waiting_time_o, e.wt);
        if (response_time_o !== e.rt) report_mismatch("response", response_time_o, e.rt);
        if (all_done_o !== e.alld) report_mismatch("all_done", all_done_o, e.alld);
      end
    end
    if (cycles > LIMIT) begin
      $display("multi_mode_task_scheduler verification failed");
      $finish;
    end
  end

  // Receiver stall pattern: stretches of full readiness and of random stalls.
  int stall_len = 0;
  int stall_kind = 0;
  always @(posedge clk_i) begin
    if (stall_len == 0) begin
      stall_len <= $urandom_range(1, 40);
      stall_kind <= $urandom_range(0, 2);
    end else stall_len <= stall_len - 1;
    case (stall_kind)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 3) != 0);
      default: out_ready_i <= ($urandom_range(0, 4) == 0);
    endcase
  end

  task automatic send_word(logic op, logic [ID_W-1:0] id, logic [TIME_W-1:0] arr,
                           logic [TIME_W-1:0] bur);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    operation_i <= op;
    task_id_i <= id;
    arrival_time_i <= arr;
    burst_length_i <= bur;
    do @(posedge clk_i); while (!in_ready_o);
    expected_q.push_back(schedule_word(op, id, arr, bur));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (45) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_MODE) cur_mode = val[MODE_W-1:0];
    else cur_quant = val[QUANT_W-1:0];
    @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_word(OP_TICK, 8'd0, 16'd0, 16'd0);
    send_word(OP_LOAD, 8'd9, 16'd0, 16'd0);
    send_word(OP_LOAD, 8'd0, 16'd0, 16'd3);
    send_word(OP_LOAD, 8'hFF, 16'd2, 16'd1);
    send_word(OP_LOAD, 8'd0, 16'd1, 16'd2);
    repeat (4) send_word(OP_TICK, 8'd0, 16'd0, 16'd0);
    send_word(OP_LOAD, 8'd5, 16'd0, 16'd2);
    repeat (5) send_word(OP_TICK, 8'd0, 16'd0, 16'd0);
    send_word(OP_LOAD, 8'd7, 16'hFFFF, 16'hFFFF);
    repeat (2) send_word(OP_TICK, 8'd0, 16'd0, 16'd0);
    drain();
  endtask

  task automatic test_phase(logic [MODE_W-1:0] m, logic [QUANT_W-1:0] q, int n);
    logic [TIME_W-1:0] arr, bur;
    write_reg(CFG_MODE, CFG_DATA_W'(m));
    write_reg(CFG_QUANTUM, q);
    for (int i = 0; i < n; i++) begin
      if ((n_loaded < SLOTS && $urandom_range(0, 30) == 0) || $urandom_range(0, 25) == 0) begin
        arr = ($urandom_range(0, 4) == 0 && sys_time > 20)
              ? TIME_W'(sys_time - $urandom_range(1, 20))
              : TIME_W'(sys_time + $urandom_range(0, 30));
        bur = ($urandom_range(0, 8) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
        send_word(OP_LOAD, 8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 2)
                                                        : $urandom_range(0, 255)), arr, bur);
      end else send_word(OP_TICK, 8'($urandom), 16'($urandom), 16'($urandom));
    end
    drain();
  endtask

  initial begin
    for (int s = 0; s < SLOTS; s++) begin
      tk_valid[s] = 0;
      tk_started[s] = 0;
      tk_joined[s] = 0;
      tk_id[s] = 0;
      tk_arr[s] = 0;
      tk_burst[s] = 0;
      tk_rem[s] = 0;
      tk_first[s] = 0;
      ready_q[s] = 0;
    end
    ready_n = 0;
    sys_time = 0;
    slice_n = 0;
    act_slot = 0;
    act_on = 0;
    n_loaded = 0;
    n_done = 0;
    cur_mode = MODE_FCFS;
    cur_quant = 1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    test_phase(MODE_FCFS, 8'd1, 150);
    test_phase(MODE_SRTF, 8'd1, 150);
    test_phase(MODE_RR, 8'd1, 150);
    test_phase(MODE_RR, 8'd255, 140);
    test_phase(MODE_UNUSED, 8'd3, 140);
    test_phase(MODE_RR, 8'd0, 150);
    test_phase(MODE_RR, 8'd3, 150);
    if (errors == 0) $display("multi_mode_task_scheduler verification clean");
    else $display("multi_mode_task_scheduler verification failed");
    $finish;
  end

endmodule

`default_nettype wire
